// ===== hdl/atr_pkg.sv =====
// Shared constants, types and the ratio-product helper for the atan2 angle pipeline.
// Depends on nothing; every other file of the block imports it.
package atr_pkg;

   localparam int IN_BITS             = 16;
   localparam int ANGLE_FRACTION_BITS = 7;
   localparam int OUT_BITS            = ANGLE_FRACTION_BITS + 9;

   localparam int RATIO_BITS  = 16;
   localparam int RATIO_SHIFT = RATIO_BITS + 1;
   localparam int RQ_BITS     = RATIO_SHIFT + 1;
   localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

   localparam int RATIO_STEPS_PER_STAGE = 3;
   localparam int RATIO_STAGES =
      (RATIO_SHIFT + RATIO_STEPS_PER_STAGE - 1) / RATIO_STEPS_PER_STAGE;

   localparam int COEF_BITS = 32;
   localparam logic [COEF_BITS-1:0] COEF1 = 32'd338;
   localparam logic [COEF_BITS-1:0] COEF2 = 32'd1073713441;
   localparam logic [COEF_BITS-1:0] COEF3 = 32'd158312570;
   localparam logic [COEF_BITS-1:0] COEF4 = 32'd332840025;
   localparam logic [COEF_BITS-1:0] COEF5 = 32'd54011108;
   localparam logic [COEF_BITS-1:0] COEF6 = 32'd157951624;
   localparam logic [COEF_BITS-1:0] COEF7 = 32'd691988024;
   localparam logic [COEF_BITS-1:0] Q_ONE = 32'd1073741824;

   localparam int K_BITS = 30;
   localparam logic [K_BITS-1:0] DEG_K = 30'd961263669;

   localparam int PROD_W     = COEF_BITS + K_BITS;
   localparam int SUM_W      = PROD_W + 1;
   localparam int DEG_SHIFT  = 24 - ANGLE_FRACTION_BITS;

   localparam int ANGLE_STEPS_PER_STAGE = 2;
   localparam int ANGLE_STAGES =
      (OUT_BITS + ANGLE_STEPS_PER_STAGE - 1) / ANGLE_STEPS_PER_STAGE;

   localparam logic [OUT_BITS-1:0] FOLD_90  = OUT_BITS'(90)  << ANGLE_FRACTION_BITS;
   localparam logic [OUT_BITS-1:0] FOLD_180 = OUT_BITS'(180) << ANGLE_FRACTION_BITS;

   typedef struct packed {
      logic y_gt_x;
      logic x_neg;
      logic y_neg;
   } atr_flags_type;

   // Product with a Q0.16 ratio, rounded half up back to the coefficient format.
   function automatic logic [COEF_BITS-1:0] mul_ratio(input logic [COEF_BITS-1:0] a,
                                                      input logic [RATIO_BITS-1:0] r);
      logic [COEF_BITS+RATIO_BITS:0] p;
      p = (COEF_BITS+RATIO_BITS+1)'(a) * (COEF_BITS+RATIO_BITS+1)'(r);
      p = p + (COEF_BITS+RATIO_BITS+1)'(1 << (RATIO_BITS - 1));
      return p[COEF_BITS+RATIO_BITS-1:RATIO_BITS];
   endfunction

endpackage

// ===== hdl/atr_ratio_div.sv =====
// Magnitude split and pipelined restoring divider forming the Q0.16 min/max ratio.
// Depends on atr_pkg.
module atr_ratio_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [atr_pkg::IN_BITS-1:0]        y_value,
   input  logic [atr_pkg::IN_BITS-1:0]        x_value,
   output logic                               out_valid,
   output logic [atr_pkg::RATIO_BITS-1:0]     ratio,
   output atr_pkg::atr_flags_type             out_flags
);
   import atr_pkg::*;

   logic [IN_BITS-1:0] ay, ax, hi, lo, rem0;
   logic               top_bit;
   atr_flags_type      flags0;

   logic                valid_ff [0:RATIO_STAGES];
   logic [IN_BITS-1:0]  rem_ff   [0:RATIO_STAGES];
   logic [IN_BITS-1:0]  hi_ff    [0:RATIO_STAGES];
   logic [RQ_BITS-1:0]  quo_ff   [0:RATIO_STAGES];
   logic                zero_ff  [0:RATIO_STAGES];
   atr_flags_type       flags_ff [0:RATIO_STAGES];

   logic [IN_BITS-1:0]  rem_in [1:RATIO_STAGES];
   logic [RQ_BITS-1:0]  quo_in [1:RATIO_STAGES];

   logic                    out_valid_ff;
   logic [RATIO_BITS-1:0]   ratio_ff, ratio_in;
   atr_flags_type           out_flags_ff;
   logic [RQ_BITS:0]        rounded;

   always_comb begin
      ay = y_value[IN_BITS-1] ? IN_BITS'(~y_value + 1'b1) : y_value;
      ax = x_value[IN_BITS-1] ? IN_BITS'(~x_value + 1'b1) : x_value;
      flags0.y_gt_x = ay > ax;
      flags0.x_neg  = x_value[IN_BITS-1];
      flags0.y_neg  = y_value[IN_BITS-1];
      hi = flags0.y_gt_x ? ay : ax;
      lo = flags0.y_gt_x ? ax : ay;
      // The leading quotient bit is set only when both magnitudes are equal.
      top_bit = lo >= hi;
      rem0 = top_bit ? IN_BITS'(lo - hi) : lo;
   end

   for (genvar s = 1; s <= RATIO_STAGES; s++) begin : g_step
      always_comb begin : step_blk
         logic [IN_BITS:0]   sh;
         logic [IN_BITS-1:0] r;
         logic [RQ_BITS-1:0] q;
         r = rem_ff[s-1];
         q = quo_ff[s-1];
         for (int k = 0; k < RATIO_STEPS_PER_STAGE; k++) begin
            if ((s - 1) * RATIO_STEPS_PER_STAGE + k < RATIO_SHIFT) begin
               sh = {r, 1'b0};
               if (sh >= {1'b0, hi_ff[s-1]}) begin
                  sh = sh - {1'b0, hi_ff[s-1]};
                  q  = {q[RQ_BITS-2:0], 1'b1};
               end else begin
                  q  = {q[RQ_BITS-2:0], 1'b0};
               end
               r = sh[IN_BITS-1:0];
            end
         end
         rem_in[s] = r;
         quo_in[s] = q;
      end
   end

   always_comb begin
      rounded = ({1'b0, quo_ff[RATIO_STAGES]} + 1'b1) >> 1;
      if (zero_ff[RATIO_STAGES]) begin
         ratio_in = '0;
      end else if (rounded > (RQ_BITS+1)'(RATIO_MAX)) begin
         ratio_in = RATIO_MAX;
      end else begin
         ratio_in = rounded[RATIO_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= RATIO_STAGES; i++) valid_ff[i] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i <= RATIO_STAGES; i++) valid_ff[i] <= valid_ff[i-1];
         out_valid_ff <= valid_ff[RATIO_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]   <= rem0;
         hi_ff[0]    <= hi;
         quo_ff[0]   <= {{(RQ_BITS-1){1'b0}}, top_bit};
         zero_ff[0]  <= hi == '0;
         flags_ff[0] <= flags0;
         for (int i = 1; i <= RATIO_STAGES; i++) begin
            rem_ff[i]   <= rem_in[i];
            hi_ff[i]    <= hi_ff[i-1];
            quo_ff[i]   <= quo_in[i];
            zero_ff[i]  <= zero_ff[i-1];
            flags_ff[i] <= flags_ff[i-1];
         end
         ratio_ff     <= ratio_in;
         out_flags_ff <= flags_ff[RATIO_STAGES];
      end
   end

   assign out_valid = out_valid_ff;
   assign ratio     = ratio_ff;
   assign out_flags = out_flags_ff;

endmodule

// ===== hdl/atr_poly.sv =====
// Four-stage Horner evaluation of the rational numerator and denominator.
// Depends on atr_pkg (coefficients and mul_ratio).
module atr_poly (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [atr_pkg::RATIO_BITS-1:0]   ratio,
   input  atr_pkg::atr_flags_type           in_flags,
   output logic                             out_valid,
   output logic [atr_pkg::COEF_BITS-1:0]    num,
   output logic [atr_pkg::COEF_BITS-1:0]    den,
   output atr_pkg::atr_flags_type           out_flags
);
   import atr_pkg::*;

   logic                  valid_ff [0:3];
   atr_flags_type         flags_ff [0:3];
   logic [RATIO_BITS-1:0] r_ff     [0:2];
   logic [COEF_BITS-1:0]  t0_ff, t1_ff, t2_ff, num_ff;
   logic [COEF_BITS-1:0]  d0_ff, den1_ff, den2_ff, den3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff[0] <= in_flags;
         for (int i = 1; i < 4; i++) flags_ff[i] <= flags_ff[i-1];
         r_ff[0] <= ratio;
         r_ff[1] <= r_ff[0];
         r_ff[2] <= r_ff[1];
         t0_ff   <= COEF4 - mul_ratio(COEF5, ratio);
         d0_ff   <= COEF6 + mul_ratio(COEF7, ratio);
         t1_ff   <= COEF3 + mul_ratio(t0_ff, r_ff[0]);
         den1_ff <= Q_ONE + mul_ratio(d0_ff, r_ff[0]);
         t2_ff   <= COEF2 + mul_ratio(t1_ff, r_ff[1]);
         den2_ff <= den1_ff;
         num_ff  <= COEF1 + mul_ratio(t2_ff, r_ff[2]);
         den3_ff <= den2_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign num       = num_ff;
   assign den       = den3_ff;
   assign out_flags = flags_ff[3];

endmodule

// ===== hdl/atr_angle_div.sv =====
// Degree scaling and pipelined restoring divider giving the first-octant angle.
// Depends on atr_pkg.
module atr_angle_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic [atr_pkg::COEF_BITS-1:0]    num,
   input  logic [atr_pkg::COEF_BITS-1:0]    den,
   input  atr_pkg::atr_flags_type           in_flags,
   output logic                             out_valid,
   output logic [atr_pkg::OUT_BITS-1:0]     mag,
   output atr_pkg::atr_flags_type           out_flags
);
   import atr_pkg::*;

   logic                 pv_ff;
   atr_flags_type        pflags_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [COEF_BITS-1:0] pden_ff;

   logic [SUM_W-1:0]     sum, xd;

   logic                 valid_ff [0:ANGLE_STAGES];
   atr_flags_type        flags_ff [0:ANGLE_STAGES];
   logic [COEF_BITS-1:0] rem_ff   [0:ANGLE_STAGES];
   logic [OUT_BITS-1:0]  low_ff   [0:ANGLE_STAGES];
   logic [OUT_BITS-1:0]  quo_ff   [0:ANGLE_STAGES];
   logic [COEF_BITS-1:0] den_ff   [0:ANGLE_STAGES];

   logic [COEF_BITS-1:0] rem_in [1:ANGLE_STAGES];
   logic [OUT_BITS-1:0]  low_in [1:ANGLE_STAGES];
   logic [OUT_BITS-1:0]  quo_in [1:ANGLE_STAGES];

   // Rounding term is half the scaled divisor; dividing by den << DEG_SHIFT
   // equals dividing the shifted-down sum by den.
   always_comb begin
      sum = SUM_W'(prod_ff) + (SUM_W'(pden_ff) << (DEG_SHIFT - 1));
      xd  = sum >> DEG_SHIFT;
   end

   for (genvar s = 1; s <= ANGLE_STAGES; s++) begin : g_step
      always_comb begin : step_blk
         logic [COEF_BITS:0]   sh;
         logic [COEF_BITS-1:0] r;
         logic [OUT_BITS-1:0]  lw;
         logic [OUT_BITS-1:0]  q;
         r  = rem_ff[s-1];
         lw = low_ff[s-1];
         q  = quo_ff[s-1];
         for (int k = 0; k < ANGLE_STEPS_PER_STAGE; k++) begin
            if ((s - 1) * ANGLE_STEPS_PER_STAGE + k < OUT_BITS) begin
               sh = {r, lw[OUT_BITS-1]};
               lw = {lw[OUT_BITS-2:0], 1'b0};
               if (sh >= {1'b0, den_ff[s-1]}) begin
                  sh = sh - {1'b0, den_ff[s-1]};
                  q  = {q[OUT_BITS-2:0], 1'b1};
               end else begin
                  q  = {q[OUT_BITS-2:0], 1'b0};
               end
               r = sh[COEF_BITS-1:0];
            end
         end
         rem_in[s] = r;
         low_in[s] = lw;
         quo_in[s] = q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         for (int i = 0; i <= ANGLE_STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         pv_ff       <= in_valid;
         valid_ff[0] <= pv_ff;
         for (int i = 1; i <= ANGLE_STAGES; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= PROD_W'(num) * PROD_W'(DEG_K);
         pden_ff     <= den;
         pflags_ff   <= in_flags;
         rem_ff[0]   <= xd[OUT_BITS+COEF_BITS-1:OUT_BITS];
         low_ff[0]   <= xd[OUT_BITS-1:0];
         quo_ff[0]   <= '0;
         den_ff[0]   <= pden_ff;
         flags_ff[0] <= pflags_ff;
         for (int i = 1; i <= ANGLE_STAGES; i++) begin
            rem_ff[i]   <= rem_in[i];
            low_ff[i]   <= low_in[i];
            quo_ff[i]   <= quo_in[i];
            den_ff[i]   <= den_ff[i-1];
            flags_ff[i] <= flags_ff[i-1];
         end
      end
   end

   assign out_valid = valid_ff[ANGLE_STAGES];
   assign mag       = quo_ff[ANGLE_STAGES];
   assign out_flags = flags_ff[ANGLE_STAGES];

endmodule

// ===== hdl/atan2_rational_approx_degrees.sv =====
// Four-quadrant atan2 in units of 1/128 degree. An accepted request passes through
// the ratio divider, the Horner stages, the degree divider and the output register
// in that order. Throughput is one request per cycle; the whole pipeline holds
// only while a result waits unread.
// Reset is synchronous and active high and clears the valid bits only.
// Depends on atr_pkg, atr_ratio_div, atr_poly and atr_angle_div.
module atan2_rational_approx_degrees (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [atr_pkg::IN_BITS-1:0]  req_y_value,
   input  logic signed [atr_pkg::IN_BITS-1:0]  req_x_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [atr_pkg::OUT_BITS-1:0] rsp_angle_degrees
);
   import atr_pkg::*;

   // One enable advances every stage together. Stages move whenever the output
   // register is empty or its result is being taken in this cycle.
   logic en;

   logic                  rat_valid;
   logic [RATIO_BITS-1:0] rat_ratio;
   atr_flags_type         rat_flags;

   logic                  poly_valid;
   logic [COEF_BITS-1:0]  poly_num, poly_den;
   atr_flags_type         poly_flags;

   logic                  ang_valid;
   logic [OUT_BITS-1:0]   ang_mag;
   atr_flags_type         ang_flags;

   logic [OUT_BITS-1:0]   fold1, fold2, angle_in;
   logic                  rsp_valid_ff;
   logic [OUT_BITS-1:0]   rsp_angle_ff;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   atr_ratio_div u_ratio (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .y_value   (req_y_value),
      .x_value   (req_x_value),
      .out_valid (rat_valid),
      .ratio     (rat_ratio),
      .out_flags (rat_flags)
   );

   atr_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rat_valid),
      .ratio     (rat_ratio),
      .in_flags  (rat_flags),
      .out_valid (poly_valid),
      .num       (poly_num),
      .den       (poly_den),
      .out_flags (poly_flags)
   );

   atr_angle_div u_angle (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (poly_valid),
      .num       (poly_num),
      .den       (poly_den),
      .in_flags  (poly_flags),
      .out_valid (ang_valid),
      .mag       (ang_mag),
      .out_flags (ang_flags)
   );

   // Octant fold: reflect about 45 degrees when |y| > |x|, about 90 degrees
   // when x is negative, and negate for a negative y. Arithmetic wraps at the
   // output width, which is exactly the width of the result.
   always_comb begin
      fold1    = ang_flags.y_gt_x ? OUT_BITS'(FOLD_90 - ang_mag) : ang_mag;
      fold2    = ang_flags.x_neg  ? OUT_BITS'(FOLD_180 - fold1) : fold1;
      angle_in = ang_flags.y_neg  ? OUT_BITS'(~fold2 + 1'b1) : fold2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= ang_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_angle_ff <= angle_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_angle_degrees = rsp_angle_ff;

endmodule
